// File: rtl/core/sbm_pkg.sv
// ============================================================================
// sbm_pkg: shared types and constants of the sentence boundary marker
// Character codes, channel item types, the command word that travels
// from the front end to the back end, and the state encodings.
// ============================================================================
package sbm_pkg;

  typedef logic [7:0] byte_t;

  // Characters used by the rules and the markers
  localparam byte_t ChPeriod  = 8'h2E;
  localparam byte_t ChSpace   = 8'h20;
  localparam byte_t ChNewline = 8'h0A;
  localparam byte_t ChQuest   = 8'h3F;
  localparam byte_t ChExclam  = 8'h21;
  localparam byte_t ChLt      = 8'h3C;
  localparam byte_t ChGt      = 8'h3E;
  localparam byte_t ChSlash   = 8'h2F;
  localparam byte_t ChLowerS  = 8'h73;
  localparam byte_t DigitLo   = 8'd48;
  localparam byte_t DigitHi   = 8'd57;

  // Window: entry 0 is the previous byte, 1..5 current plus lookahead
  localparam int WinDepth    = 6;
  localparam logic [2:0] WinFull = 3'd5;

  // Command queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;

  typedef byte_t [WinDepth-1:0] win_t;

  typedef struct packed {
    byte_t text_byte;
    logic  last_of_text;
  } text_item_t;

  typedef struct packed {
    byte_t out_byte;
    logic  last_of_run;
    logic  end_of_text;
  } marked_item_t;

  // One command expands to: opening marker, literals, sentence end,
  // tail character, closing marker (each part optional).
  typedef struct packed {
    logic            open_mark;
    byte_t [3:0]     lits;
    logic [2:0]      lit_count;
    logic            send;
    logic            tail_valid;
    byte_t           tail_byte;
    logic            close_mark;
    logic            last;
  } cmd_t;

  typedef enum logic {
    FR_RUN,
    FR_FLUSH
  } front_state_t;

  typedef enum logic [2:0] {
    SEG_OPEN  = 3'd0,
    SEG_LIT   = 3'd1,
    SEG_SEND  = 3'd2,
    SEG_TAIL  = 3'd3,
    SEG_CLOSE = 3'd4
  } seg_t;

  typedef struct packed {
    logic found;
    seg_t seg;
  } seg_pick_t;

endpackage

// File: rtl/core/sbm_queue.sv
// ============================================================================
// sbm_queue: command queue
// Small register FIFO that decouples the classifier from the expander.
// ============================================================================
module sbm_queue import sbm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t               slots [QueueDepth];
  logic [QueueAw-1:0] wr_ptr;
  logic [QueueAw-1:0] rd_ptr;
  logic [QueueAw:0]   count;

  logic do_push;
  logic do_pop;

  assign full    = count == (QueueAw+1)'(QueueDepth);
  assign empty   = count == '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// File: rtl/core/sbm_front.sv
// ============================================================================
// sbm_front: window and rule classifier
// Takes text bytes into the lookahead window and, while the queue is not full, decides one
// position per cycle and pushes a command describing its output into the queue.
// ============================================================================
module sbm_front import sbm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  text_item_t text_item,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       queue_full
);

  typedef struct packed {
    byte_t [3:0] lits;
    logic [2:0]  lit_count;
    logic        send;
    logic [2:0]  jump;
  } rule_t;

  function automatic logic is_digit(byte_t ch);
    return (ch >= DigitLo) && (ch <= DigitHi);
  endfunction

  // p: previous byte, a: current, b..e: lookahead
  function automatic rule_t decide(byte_t p, byte_t a, byte_t b, byte_t c,
                                   byte_t d, byte_t e);
    rule_t r;
    r.lits      = '0;
    r.lits[0]   = a;
    r.lit_count = 3'd1;
    r.send      = 1'b0;
    r.jump      = 3'd0;
    if (a == ChPeriod) begin
      if (b == ChSpace) begin
        r.lit_count = 3'd0;
        r.send      = 1'b1;
        r.jump      = (c != ChNewline) ? 3'd1 : 3'd2;
      end else if (is_digit(b) || is_digit(p)) begin
        r.lit_count = 3'd1;   // decimal point kept
      end else if (b == ChNewline) begin
        r.lit_count = 3'd0;
        r.send      = 1'b1;
        r.jump      = 3'd1;
      end else begin
        r.lit_count = 3'd0;
        r.send      = 1'b1;
      end
    end else if (is_digit(a) && (b == ChPeriod)) begin
      if (is_digit(c)) begin
        r.lits[1]   = b;
        r.lits[2]   = c;
        r.lit_count = 3'd3;
        if (is_digit(d)) begin
          r.lits[3]   = d;
          r.lit_count = 3'd4;
          if (e == ChPeriod) begin
            r.send = 1'b1;
            r.jump = 3'd4;
          end else begin
            r.jump = 3'd3;
          end
        end else if (d == ChPeriod) begin
          r.send = 1'b1;
          r.jump = 3'd3;
        end else begin
          r.jump = 3'd2;
        end
      end else if (c == ChSpace) begin
        if (p != ChNewline) begin
          r.send = 1'b1;
        end else begin
          r.lits[1]   = b;
          r.lits[2]   = c;
          r.lit_count = 3'd3;
        end
        r.jump = 3'd2;
      end else begin
        r.jump = 3'd1;
      end
    end else if (a == ChNewline) begin
      r.lit_count = 3'd0;
      r.send      = 1'b1;
    end else if (((a == ChQuest) || (a == ChExclam)) && (b == ChSpace)) begin
      r.send = 1'b1;
    end
    return r;
  endfunction

  // Drop k positions off the front; zeros come in at the top
  function automatic win_t shift_win(win_t w, logic [2:0] k);
    return win_t'(w >> {k, 3'b000});
  endfunction

  win_t         win;
  logic [2:0]   fill;
  logic         prefix_sent;
  front_state_t state;

  win_t         win_next;
  logic [2:0]   fill_next;
  logic         prefix_next;
  front_state_t state_next;

  win_t       win_app;
  logic [2:0] fill_app;
  logic       take;
  rule_t      rule;
  logic       has_rule;
  logic [2:0] jump_c;
  logic [2:0] fill_one;
  win_t       win_j;
  logic       done;
  logic       flush_cycle;

  assign text_stall = queue_full || (state != FR_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      win         <= '0;
      fill        <= '0;
      prefix_sent <= 1'b0;
      state       <= FR_RUN;
    end else begin
      win         <= win_next;
      fill        <= fill_next;
      prefix_sent <= prefix_next;
      state       <= state_next;
    end
  end

  always_comb begin
    win_app  = win;
    fill_app = fill;
    take     = (state == FR_RUN) && text_valid && !queue_full;
    if (state == FR_RUN) begin
      win_app[3'(fill + 3'd1)] = text_item.text_byte;
      fill_app                 = fill + 3'd1;
    end

    rule     = decide(win_app[0], win_app[1], win_app[2], win_app[3],
                      win_app[4], win_app[5]);
    has_rule = fill_app >= 3'd2;
    jump_c   = 3'd0;
    if (has_rule) begin
      jump_c = (rule.jump > (fill_app - 3'd1)) ? (fill_app - 3'd1) : rule.jump;
    end
    fill_one    = fill_app - jump_c;
    win_j       = shift_win(win_app, jump_c);
    done        = fill_one <= 3'd1;
    flush_cycle = (take && text_item.last_of_text) ||
                  ((state == FR_FLUSH) && !queue_full);

    push        = 1'b0;
    push_cmd    = '0;
    win_next    = win;
    fill_next   = fill;
    prefix_next = prefix_sent;
    state_next  = state;

    if (take && !text_item.last_of_text) begin
      prefix_next        = 1'b1;
      push_cmd.open_mark = !prefix_sent;
      push_cmd.last      = 1'b1;
      if (fill_app == WinFull) begin
        push               = 1'b1;
        push_cmd.lits      = rule.lits;
        push_cmd.lit_count = rule.lit_count;
        push_cmd.send      = rule.send;
        win_next           = shift_win(win_app, rule.jump + 3'd1);
        fill_next          = fill_app - rule.jump - 3'd1;
      end else begin
        push      = !prefix_sent;
        win_next  = win_app;
        fill_next = fill_app;
      end
    end else if (flush_cycle) begin
      // one flush position per cycle while the queue is not full
      push               = 1'b1;
      push_cmd.open_mark = (state == FR_RUN) && !prefix_sent;
      if (has_rule) begin
        push_cmd.lits      = rule.lits;
        push_cmd.lit_count = rule.lit_count;
        push_cmd.send      = rule.send;
      end
      if (done) begin
        push_cmd.tail_valid = (fill_one == 3'd1) && (win_j[1] != ChPeriod) &&
                              (win_j[1] != ChSpace) && (win_j[1] != ChNewline);
        push_cmd.tail_byte  = win_j[1];
        push_cmd.close_mark = 1'b1;
        push_cmd.last       = 1'b1;
        win_next            = '0;
        fill_next           = 3'd0;
        prefix_next         = 1'b0;
        state_next          = FR_RUN;
      end else begin
        win_next    = shift_win(win_app, jump_c + 3'd1);
        fill_next   = fill_one - 3'd1;
        prefix_next = 1'b1;
        state_next  = FR_FLUSH;
      end
    end
  end

endmodule

// File: rtl/core/sbm_back.sv
// ============================================================================
// sbm_back: command expander
// Pops commands and writes them out one byte per cycle, unless a valid output is
// stalled, through an output register.
// ============================================================================
module sbm_back import sbm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         empty,
  input  cmd_t         head,
  output logic         pop,
  output logic         marked_valid,
  input  logic         marked_stall,
  output marked_item_t marked_item
);

  function automatic logic [4:0] seg_mask(cmd_t c);
    return {c.close_mark, c.tail_valid, c.send, c.lit_count != 3'd0, c.open_mark};
  endfunction

  // lowest present part at or after start
  function automatic seg_pick_t pick_seg(logic [4:0] mask, logic [2:0] start);
    seg_pick_t r;
    r.found = 1'b0;
    r.seg   = SEG_CLOSE;
    for (int i = 4; i >= 0; i--) begin
      if (mask[i] && (3'(i) >= start)) begin
        r.found = 1'b1;
        r.seg   = seg_t'(3'(i));
      end
    end
    return r;
  endfunction

  function automatic byte_t open_char(logic [1:0] i);
    case (i)
      2'd0:    return ChLt;
      2'd1:    return ChLowerS;
      2'd2:    return ChGt;
      default: return ChSpace;
    endcase
  endfunction

  function automatic byte_t close_char(logic [1:0] i);
    case (i)
      2'd0:    return ChLt;
      2'd1:    return ChSlash;
      2'd2:    return ChLowerS;
      default: return ChGt;
    endcase
  endfunction

  // "</s>\n<s> "
  function automatic byte_t send_char(logic [3:0] i);
    case (i)
      4'd0:    return ChLt;
      4'd1:    return ChSlash;
      4'd2:    return ChLowerS;
      4'd3:    return ChGt;
      4'd4:    return ChNewline;
      4'd5:    return ChLt;
      4'd6:    return ChLowerS;
      4'd7:    return ChGt;
      default: return ChSpace;
    endcase
  endfunction

  cmd_t       cur;
  logic       cur_valid;
  seg_t       seg;
  logic [3:0] idx;

  logic       advance;
  logic [3:0] seg_len;
  logic       seg_end;
  seg_pick_t  nxt;
  seg_pick_t  first;
  logic       cmd_final;
  logic       load;
  byte_t      cur_byte;

  always_comb begin
    case (seg)
      SEG_OPEN:  seg_len = 4'd4;
      SEG_LIT:   seg_len = {1'b0, cur.lit_count};
      SEG_SEND:  seg_len = 4'd9;
      SEG_TAIL:  seg_len = 4'd1;
      SEG_CLOSE: seg_len = 4'd4;
      default:   seg_len = 4'd1;
    endcase
    case (seg)
      SEG_OPEN:  cur_byte = open_char(idx[1:0]);
      SEG_LIT:   cur_byte = cur.lits[idx[1:0]];
      SEG_SEND:  cur_byte = send_char(idx);
      SEG_TAIL:  cur_byte = cur.tail_byte;
      SEG_CLOSE: cur_byte = close_char(idx[1:0]);
      default:   cur_byte = cur.tail_byte;
    endcase
  end

  assign advance   = cur_valid && (!marked_valid || !marked_stall);
  assign seg_end   = idx == (seg_len - 4'd1);
  assign nxt       = pick_seg(seg_mask(cur), 3'(seg) + 3'd1);
  assign first     = pick_seg(seg_mask(head), 3'd0);
  assign cmd_final = seg_end && !nxt.found;
  assign load      = !cur_valid || (advance && cmd_final);
  assign pop       = load && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid    <= 1'b0;
      marked_valid <= 1'b0;
    end else begin
      if (advance)            marked_valid <= 1'b1;
      else if (!marked_stall) marked_valid <= 1'b0;
      if (load)               cur_valid    <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      marked_item.out_byte    <= cur_byte;
      marked_item.last_of_run <= cmd_final && cur.last;
      marked_item.end_of_text <= (seg == SEG_CLOSE) && (idx == 4'd3);
    end
    if (load) begin
      cur <= head;
      seg <= first.seg;
      idx <= 4'd0;
    end else if (advance) begin
      if (seg_end) begin
        seg <= nxt.seg;
        idx <= 4'd0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

endmodule

// File: rtl/core/sentence_boundary_marker.sv
// ============================================================================
// sentence_boundary_marker: inserts sentence markers into a text stream
// Front end classifies each text position against the sentence rules,
// a four-entry command queue decouples it from the back end, which
// expands each command into marker and text bytes.
// ============================================================================
//
//  Channel   Signals                                 Moves per transfer
//  -------   -------------------------------------   -----------------------
//  text      text_valid / text_stall / text_item     one input byte + last
//  marked    marked_valid / marked_stall / marked_item  one output byte
//
// Rates: the front end takes one text byte per cycle unless the command queue is
//   full; the byte marked last then flushes one buffered position per cycle while the queue has room.
// The back end writes one output byte per cycle unless a valid output is stalled;
//   a plain character is one byte, a sentence end nine; the output port sets the rate.
// Stalls: the text side stalls only when the command queue is full or a flush
//   is running; a stall on a valid output freezes the back end and the output register.
// Reset (rst, synchronous) clears the window, fill and prefix state, the queue
//   and the output valid.
//
module sentence_boundary_marker import sbm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_stall,
  input  text_item_t   text_item,
  output logic         marked_valid,
  input  logic         marked_stall,
  output marked_item_t marked_item
);

  // front -> queue
  logic push;
  cmd_t push_cmd;
  logic queue_full;

  // queue -> back
  logic pop;
  logic queue_empty;
  cmd_t queue_head;

  // Front end: lookahead window and rule decision, at most one command per cycle
  sbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_item  (text_item),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  // Command queue, lets a burst of markers drain while text keeps coming
  sbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (queue_head)
  );

  // Back end: byte-by-byte expansion into the registered output
  sbm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (queue_empty),
    .head         (queue_head),
    .pop          (pop),
    .marked_valid (marked_valid),
    .marked_stall (marked_stall),
    .marked_item  (marked_item)
  );

endmodule

// File: rtl/core/sbm_checker.sv
// ============================================================================
// sbm_checker: port-level checks for the sentence boundary marker
// Watches the top level's channels; attached by bind.
// ============================================================================
module sbm_checker import sbm_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         text_valid,
  input logic         text_stall,
  input text_item_t   text_item,
  input logic         marked_valid,
  input logic         marked_stall,
  input marked_item_t marked_item
);

  // stalled input keeps its valid and payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid && $stable(text_item))
    else $error("input transfer changed while stalled");

  // stalled output keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    marked_valid && marked_stall |=> marked_valid)
    else $error("output valid dropped while stalled");

  // stalled output keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    marked_valid && marked_stall |=> $stable(marked_item))
    else $error("output payload changed while stalled");

  // closing marker ends on '>' and closes the run
  a_end_mark: assert property (@(posedge clk) disable iff (rst)
    marked_valid && marked_item.end_of_text |->
      marked_item.last_of_run && (marked_item.out_byte == ChGt))
    else $error("end of text not on final closing byte");

  // after reset: nothing pending, input open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !marked_valid && !text_stall)
    else $error("block not idle after reset");

endmodule

bind sentence_boundary_marker sbm_checker u_sbm_checker (.*);

// File: sim/tb_sentence_boundary_marker.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sentence_boundary_marker: self-checking bench for the sentence marker
// Drives short directed texts and then random texts through the text
// channel. Each accepted text byte runs through a local model of the
// rewrite rules, and every marked byte that leaves the block is compared
// with the oldest byte the model still has pending.
// ============================================================================
module tb_sentence_boundary_marker;
  import sbm_pkg::*;

  // No transfer on either side for this many cycles means the block hung.
  // The longest quiet stretch the bench itself causes is the long output hold
  // (LongHold), so HangLimit leaves plenty of margin.
  localparam int HangLimit   = 2000;
  localparam int LongHold    = 400;
  localparam int RandomItems = 420;
  localparam int TailCycles  = 64;

  localparam byte_t SentenceBreak [9] = '{ChLt, ChSlash, ChLowerS, ChGt, ChNewline,
                                          ChLt, ChLowerS, ChGt, ChSpace};
  localparam byte_t OpenMark [4] = '{ChLt, ChLowerS, ChGt, ChSpace};

  typedef struct {
    byte_t ch;
    logic  last;
    string typed;   // empty: expected bytes come from the model
  } text_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         text_valid = 1'b0;
  logic         text_stall;
  text_item_t   text_item = '0;
  logic         marked_valid;
  logic         marked_stall = 1'b0;
  marked_item_t marked_item;

  sentence_boundary_marker DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .marked_valid (marked_valid),
    .marked_stall (marked_stall),
    .marked_item  (marked_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Rule model: its own copy of the window, fill level and opening flag
  // --------------------------------------------------------------------------
  byte_t        win [6];       // 0: byte before position, 1..5: position + lookahead
  int unsigned  win_fill;
  bit           opened;
  marked_item_t step_marks[$]; // bytes caused by the current text byte
  marked_item_t marks_due[$];  // bytes still to come out of the block
  string        row_hints[$];  // typed expectation per offered byte, in order

  int err_count    = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int items_sent   = 0;
  bit tx_calm      = 1'b0;

  function automatic bit is_digit(input byte_t ch);
    return ch >= DigitLo && ch <= DigitHi;
  endfunction

  function automatic byte_t peek(input int unsigned i);
    return (i < win_fill && i < 5) ? win[1 + i] : 8'h00;
  endfunction

  function automatic void clear_window();
    foreach (win[i]) win[i] = 8'h00;
    win_fill = 0;
    opened   = 1'b0;
  endfunction

  function automatic void shift_window();
    if (win_fill == 0) return;
    for (int i = 0; i < 5; i++) win[i] = win[i + 1];
    win[5] = 8'h00;
    win_fill--;
  endfunction

  function automatic void put_mark(input byte_t ch, input logic eot);
    marked_item_t m;
    m.out_byte    = ch;
    m.last_of_run = 1'b0;
    m.end_of_text = eot;
    if (step_marks.size() < 64)
      step_marks.insert(step_marks.size(), m);
  endfunction

  function automatic void put_break();
    foreach (SentenceBreak[i]) put_mark(SentenceBreak[i], 1'b0);
  endfunction

  // Decide the byte at the current position; returns how many bytes the
  // rule consumed beyond it.
  function automatic int unsigned decide_position();
    byte_t p, a, b, c, d, e;
    int unsigned jump;
    p = win[0];
    a = peek(0);
    b = peek(1);
    c = peek(2);
    d = peek(3);
    e = peek(4);
    jump = 0;
    if (a == ChPeriod) begin
      if (b == ChSpace) begin
        put_break();
        jump = (c != ChNewline) ? 1 : 2;
      end else if (is_digit(b) || is_digit(p)) begin
        put_mark(ChPeriod, 1'b0);
      end else if (b == ChNewline) begin
        put_break();
        jump = 1;
      end else begin
        put_break();
      end
    end else if (is_digit(a) && b == ChPeriod) begin
      // digit before a period: a digit.digit group stays in one piece
      put_mark(a, 1'b0);
      if (is_digit(c)) begin
        put_mark(b, 1'b0);
        put_mark(c, 1'b0);
        if (is_digit(d)) begin
          put_mark(d, 1'b0);
          if (e == ChPeriod) begin
            put_break();
            jump = 4;
          end else begin
            jump = 3;
          end
        end else if (d == ChPeriod) begin
          put_break();
          jump = 3;
        end else begin
          jump = 2;
        end
      end else if (c == ChSpace) begin
        // a numbered line ("\n3. ") keeps its period
        if (p != ChNewline) begin
          put_break();
        end else begin
          put_mark(b, 1'b0);
          put_mark(c, 1'b0);
        end
        jump = 2;
      end else begin
        jump = 1;
      end
    end else if (a == ChNewline) begin
      put_break();
    end else if ((a == ChQuest || a == ChExclam) && b == ChSpace) begin
      put_mark(a, 1'b0);
      put_break();
    end else begin
      put_mark(a, 1'b0);
    end
    return jump;
  endfunction

  // Model one accepted text byte; leaves its output bytes in step_marks.
  function automatic void mark_text_byte(input text_item_t it);
    int unsigned  jump;
    byte_t        a;
    bit           done;
    marked_item_t tail;
    step_marks.delete();
    if (!opened) begin
      foreach (OpenMark[i]) put_mark(OpenMark[i], 1'b0);
      opened = 1'b1;
    end
    if (win_fill >= 5) win_fill = 4;
    win[1 + win_fill] = it.text_byte;
    win_fill++;
    if (!it.last_of_text) begin
      if (win_fill == 5) begin
        jump = decide_position();
        repeat (jump) shift_window();
        shift_window();
      end
    end else begin
      // flush every buffered position, then the closing marker
      done = 1'b0;
      while (!done) begin
        if (win_fill >= 2) begin
          jump = decide_position();
          if (jump > win_fill - 1) jump = win_fill - 1;
          repeat (jump) shift_window();
        end
        if (win_fill <= 1) begin
          a = peek(0);
          if (win_fill == 1 && a != ChPeriod && a != ChSpace && a != ChNewline)
            put_mark(a, 1'b0);
          put_mark(ChLt, 1'b0);
          put_mark(ChSlash, 1'b0);
          put_mark(ChLowerS, 1'b0);
          put_mark(ChGt, 1'b1);
          clear_window();
          done = 1'b1;
        end else begin
          shift_window();
        end
      end
    end
    if (step_marks.size() > 0) begin
      tail = step_marks.pop_back();
      tail.last_of_run = 1'b1;
      step_marks.insert(step_marks.size(), tail);
    end
  endfunction

  // Directed rows with a typed answer: bytes of the string, run end on the
  // last one, end of text there too when the row closes the text.
  function automatic void queue_typed(input string s, input logic closing);
    marked_item_t m;
    for (int i = 0; i < s.len(); i++) begin
      m.out_byte    = s[i];
      m.last_of_run = (i == s.len() - 1);
      m.end_of_text = closing && (i == s.len() - 1);
      marks_due.insert(marks_due.size(), m);
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  initial clear_window();

  // --------------------------------------------------------------------------
  // Scoreboard: predicts on every text transfer, checks every marked transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    string        hint;
    marked_item_t want;
    bit           moved;
    moved = 1'b0;
    if (!rst) begin
      if (text_valid && !text_stall) begin
        moved = 1'b1;
        hint  = row_hints.pop_front();
        mark_text_byte(text_item);
        if (hint.len() == 0) begin
          foreach (step_marks[i]) marks_due.insert(marks_due.size(), step_marks[i]);
        end else begin
          queue_typed(hint, text_item.last_of_text);
        end
      end
      if (marked_valid && !marked_stall) begin
        moved = 1'b1;
        results_seen++;
        if (marks_due.size() == 0) begin
          flag_mismatch($sformatf("byte %02h with nothing pending", marked_item.out_byte));
        end else begin
          want = marks_due.pop_front();
          if (marked_item.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %02h, want %02h",
                                    marked_item.out_byte, want.out_byte));
          if (marked_item.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
                                    marked_item.last_of_run, want.last_of_run,
                                    want.out_byte));
          if (marked_item.end_of_text !== want.end_of_text)
            flag_mismatch($sformatf("end_of_text %b, want %b on byte %02h",
                                    marked_item.end_of_text, want.end_of_text,
                                    want.out_byte));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < HangLimit) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall per byte, calm stretches, one long hold so the
  // command queue fills and the text side backs up
  // --------------------------------------------------------------------------
  initial begin : sink
    int unsigned gap;
    bit          rx_calm;
    bit          held_long;
    rx_calm   = 1'b0;
    held_long = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      if (!held_long && results_seen >= 400) begin
        held_long = 1'b1;
        gap = LongHold;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        marked_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      marked_stall <= 1'b0;
      @(posedge clk);
      while (!marked_valid) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Text side
  // --------------------------------------------------------------------------
  task automatic offer_byte(input byte_t ch, input logic last, input string hint);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_hints.insert(row_hints.size(), hint);
    text_item  <= '{text_byte: ch, last_of_text: last};
    text_valid <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the text side until every pending byte has come out.
  task automatic drain_marks();
    text_valid <= 1'b0;
    @(posedge clk);
    while (marks_due.size() != 0) @(posedge clk);
  endtask

  // Weighted toward the characters the rules care about, with some noise.
  function automatic byte_t pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return byte_t'(8'h61 + $urandom_range(0, 25));
    if (r < 40) return byte_t'(DigitLo + $urandom_range(0, 9));
    if (r < 55) return ChPeriod;
    if (r < 70) return ChSpace;
    if (r < 78) return ChNewline;
    if (r < 84) return ChQuest;
    if (r < 90) return ChExclam;
    return byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_text();
    int unsigned len;
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned k = 1; k <= len; k++) offer_byte(pick_char(), k == len, "");
  endtask

  text_row_t dir_rows [24];

  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    dir_rows = '{
      '{8'h41,     1'b0, "<s> "},       // first byte opens the text
      '{8'h00,     1'b0, ""},           // zero byte is a plain character
      '{ChPeriod,  1'b0, ""},           // period then space
      '{ChSpace,   1'b0, ""},
      '{8'h31,     1'b0, ""},           // digit period digit
      '{ChPeriod,  1'b0, ""},
      '{8'h35,     1'b0, ""},
      '{ChQuest,   1'b0, ""},           // question mark then space
      '{ChSpace,   1'b0, ""},
      '{ChNewline, 1'b0, ""},
      '{8'hFF,     1'b0, ""},
      '{ChExclam,  1'b0, ""},
      '{ChSpace,   1'b0, ""},
      '{ChPeriod,  1'b1, ""},           // final period is dropped
      '{8'h5A,     1'b1, "<s> Z</s>"},  // one-byte text
      '{ChPeriod,  1'b1, "<s> </s>"},   // text of a lone period
      '{8'h32,     1'b0, ""},           // number group then a period
      '{ChPeriod,  1'b0, ""},
      '{8'h33,     1'b0, ""},
      '{8'h34,     1'b0, ""},
      '{ChPeriod,  1'b0, ""},
      '{ChSpace,   1'b0, ""},
      '{8'h78,     1'b0, ""},
      '{8'hFF,     1'b1, ""}            // top byte closes the text
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed);

    while (items_sent < $size(dir_rows) + RandomItems) begin
      send_text();
      if (!paused && items_sent >= 100) begin
        paused = 1'b1;
        drain_marks();
      end
    end

    drain_marks();
    repeat (TailCycles) @(posedge clk);
    if (marks_due.size() != 0)
      flag_mismatch($sformatf("%0d bytes never came out", marks_due.size()));

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/sbm_pkg.sv
rtl/core/sbm_queue.sv
rtl/core/sbm_front.sv
rtl/core/sbm_back.sv
rtl/core/sentence_boundary_marker.sv
rtl/core/sbm_checker.sv
sim/tb_sentence_boundary_marker.sv
